[rtl/core/lzss_pkg.sv]
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS ring decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int RING_DEPTH   = 4096;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int CNT_W        = 24;
  localparam int LEN_W        = 9;
  localparam int MIN_MATCH    = 3;
  localparam int EXT_MATCH    = 18;
  localparam int BPR_DEFAULT  = 8;
  localparam int CMDQ_DEPTH   = 4;
  localparam int OUTQ_DEPTH   = 2;

  localparam logic [RING_AW-1:0] RING_END_ADDR  = RING_AW'(RING_DEPTH - 1);
  localparam logic [3:0]         LEN_NIBBLE_EXT = 4'h0F;

  // parser phase
  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_HIGH,
    PH_EXT
  } phase_t;

  // back-end sequencer state
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } bk_state_t;

  // one unit of work for the back end: a literal or a ring copy
  typedef struct packed {
    logic               is_lit;
    logic [RING_AW-1:0] data;     // literal in bits 7:0, or ring read position
    logic [LEN_W-1:0]   len;      // bytes to produce, already clipped
    logic [CNT_W-1:0]   base;     // block output count before this command
  } cmd_t;

  typedef struct packed {
    logic [63:0]        bytes;
    logic [3:0]         byte_count;
    logic [RING_AW-1:0] ring_pos;
    logic               limit_reached;
    logic               last;
  } out_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

[rtl/core/lzss_fifo.sv]
// ----------------------------------------------------------------------------
// lzss_fifo
// Small register queue. DEPTH is a power of two, at least 2.
// ----------------------------------------------------------------------------
module lzss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/lzss_front.sv]
// ----------------------------------------------------------------------------
// lzss_front
// Token parser: turns compressed bytes into literal and copy commands,
// tracks the block output count and clips copies to the limit.
// ----------------------------------------------------------------------------
module lzss_front
  import lzss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       src_byte,
  input  logic             block_start,
  input  logic [CNT_W-1:0] output_limit,
  output logic             cmd_push,
  output cmd_t             cmd
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       flag_bits_r, flag_bits_nxt;
  logic [3:0]       flag_idx_r, flag_idx_nxt;
  logic [7:0]       ref_low_r, ref_low_nxt;
  logic [7:0]       ref_high_r, ref_high_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // state as seen by this byte, after an optional block restart
  phase_t           phase_e;
  logic [7:0]       flag_bits_e;
  logic [3:0]       flag_idx_e;
  logic [7:0]       ref_low_e;
  logic [CNT_W-1:0] count_e;
  logic [CNT_W-1:0] remain;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_clip;
  logic [3:0]       idx_inc;
  logic             is_copy;

  always_comb begin
    phase_e     = block_start ? PH_FLAG : phase_r;
    flag_bits_e = block_start ? 8'd0 : flag_bits_r;
    flag_idx_e  = block_start ? 4'd8 : flag_idx_r;
    ref_low_e   = block_start ? 8'd0 : ref_low_r;
    count_e     = block_start ? '0 : count_r;
    remain      = output_limit - count_e;
    idx_inc     = flag_idx_e + 4'd1;

    if (phase_e == PH_EXT) begin
      len_raw = LEN_W'(EXT_MATCH) + LEN_W'(src_byte);
    end else begin
      len_raw = LEN_W'(src_byte[7:4]) + LEN_W'(MIN_MATCH);
    end
    len_clip = (remain < CNT_W'(len_raw)) ? remain[LEN_W-1:0] : len_raw;

    phase_nxt     = phase_r;
    flag_bits_nxt = flag_bits_r;
    flag_idx_nxt  = flag_idx_r;
    ref_low_nxt   = ref_low_r;
    ref_high_nxt  = ref_high_r;
    count_nxt     = count_r;
    cmd_push      = 1'b0;
    is_copy       = 1'b0;
    cmd.is_lit    = 1'b1;
    cmd.data      = RING_AW'(src_byte);
    cmd.len       = LEN_W'(1);
    cmd.base      = count_e;

    if (accept) begin
      if (block_start) begin
        phase_nxt     = PH_FLAG;
        flag_bits_nxt = 8'd0;
        flag_idx_nxt  = 4'd8;
        ref_low_nxt   = 8'd0;
        ref_high_nxt  = 8'd0;
        count_nxt     = '0;
      end
      // drop the byte once the block has reached its limit
      if (count_e < output_limit) begin
        case (phase_e)
          PH_TOKEN: begin
            if (flag_bits_e[flag_idx_e[2:0]]) begin
              ref_low_nxt = src_byte;
              phase_nxt   = PH_HIGH;
            end else begin
              cmd_push     = 1'b1;
              count_nxt    = count_e + CNT_W'(1);
              flag_idx_nxt = idx_inc;
              phase_nxt    = (idx_inc >= 4'd8) ? PH_FLAG : PH_TOKEN;
            end
          end
          PH_HIGH: begin
            ref_high_nxt = src_byte;
            if (src_byte[7:4] == LEN_NIBBLE_EXT) begin
              phase_nxt = PH_EXT;
            end else begin
              is_copy      = 1'b1;
              flag_idx_nxt = idx_inc;
              phase_nxt    = (idx_inc >= 4'd8) ? PH_FLAG : PH_TOKEN;
            end
          end
          PH_EXT: begin
            is_copy      = 1'b1;
            flag_idx_nxt = idx_inc;
            phase_nxt    = (idx_inc >= 4'd8) ? PH_FLAG : PH_TOKEN;
          end
          default: begin
            flag_bits_nxt = src_byte;
            flag_idx_nxt  = 4'd0;
            phase_nxt     = PH_TOKEN;
          end
        endcase
      end
    end

    if (is_copy) begin
      cmd_push   = 1'b1;
      cmd.is_lit = 1'b0;
      cmd.len    = len_clip;
      count_nxt  = count_e + CNT_W'(len_clip);
      if (phase_e == PH_EXT) begin
        cmd.data = {ref_high_r[3:0], ref_low_e};
      end else begin
        cmd.data = {src_byte[3:0], ref_low_e};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAG;
      flag_bits_r <= 8'd0;
      flag_idx_r  <= 4'd8;
      ref_low_r   <= 8'd0;
      ref_high_r  <= 8'd0;
      count_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_idx_r  <= flag_idx_nxt;
      ref_low_r   <= ref_low_nxt;
      ref_high_r  <= ref_high_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

[rtl/core/lzss_back.sv]
// ----------------------------------------------------------------------------
// lzss_back
// Command executor: owns the history ring, writes literals and copied
// bytes at the write pointer and packs them into result items.
// ----------------------------------------------------------------------------
module lzss_back
  import lzss_pkg::*;
#(
  parameter int BYTES_PER_RESULT = BPR_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] output_limit,
  input  logic             cmd_empty,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic             out_full,
  output logic             out_push,
  output out_t             out_item,
  output bk_status_t       status
);

  logic [7:0] ring_mem [RING_DEPTH];

  bk_state_t          state_r, state_nxt;
  logic [RING_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic               is_lit_r, is_lit_nxt;
  logic [RING_AW-1:0] data_r, data_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [3:0]         acc_cnt_r, acc_cnt_nxt;
  logic [7:0]         rd_data_r;

  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_waddr;
  logic [7:0]         ring_wdata;
  logic [7:0]         wr_byte;
  logic [63:0]        acc_ins;
  logic [3:0]         cnt_inc;
  logic [CNT_W-1:0]   count_inc;
  logic               flush;

  assign status.clearing = (state_r == BK_CLEAR);

  always_comb begin
    wr_byte   = is_lit_r ? data_r[7:0] : rd_data_r;
    cnt_inc   = acc_cnt_r + 4'd1;
    count_inc = count_r + CNT_W'(1);
    flush     = (cnt_inc == 4'(BYTES_PER_RESULT)) || (rem_r == LEN_W'(1));
    acc_ins   = acc_r;
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      if (acc_cnt_r == 4'(i)) begin
        acc_ins[8*i +: 8] = wr_byte;
      end
    end

    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    wp_nxt       = wp_r;
    is_lit_nxt   = is_lit_r;
    data_nxt     = data_r;
    rem_nxt      = rem_r;
    count_nxt    = count_r;
    acc_nxt      = acc_r;
    acc_cnt_nxt  = acc_cnt_r;
    cmd_pop      = 1'b0;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    ring_waddr   = wp_r;
    ring_wdata   = wr_byte;
    out_push     = 1'b0;

    out_item.bytes         = acc_ins;
    out_item.byte_count    = cnt_inc;
    out_item.ring_pos      = wp_r + RING_AW'(1);
    out_item.limit_reached = (count_inc >= output_limit);
    out_item.last          = (rem_r == LEN_W'(1));

    case (state_r)
      BK_CLEAR: begin
        ring_we      = 1'b1;
        ring_waddr   = clr_addr_r;
        ring_wdata   = 8'd0;
        clr_addr_nxt = clr_addr_r + RING_AW'(1);
        if (clr_addr_r == RING_END_ADDR) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          is_lit_nxt = cmd.is_lit;
          data_nxt   = cmd.data;
          rem_nxt    = cmd.len;
          count_nxt  = cmd.base;
          state_nxt  = cmd.is_lit ? BK_WRITE : BK_READ;
        end
      end
      BK_READ: begin
        ring_re   = 1'b1;
        data_nxt  = data_r + RING_AW'(1);
        state_nxt = BK_WRITE;
      end
      BK_WRITE: begin
        // hold the byte while a finished result has nowhere to go
        if (!flush || !out_full) begin
          ring_we   = 1'b1;
          wp_nxt    = wp_r + RING_AW'(1);
          count_nxt = count_inc;
          rem_nxt   = rem_r - LEN_W'(1);
          if (flush) begin
            out_push    = 1'b1;
            acc_nxt     = '0;
            acc_cnt_nxt = 4'd0;
          end else begin
            acc_nxt     = acc_ins;
            acc_cnt_nxt = cnt_inc;
          end
          state_nxt = (rem_r == LEN_W'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
      wp_r       <= '0;
      acc_r      <= '0;
      acc_cnt_r  <= 4'd0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      wp_r       <= wp_nxt;
      acc_r      <= acc_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_lit_r <= is_lit_nxt;
    data_r   <= data_nxt;
    rem_r    <= rem_nxt;
    count_r  <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      rd_data_r <= ring_mem[data_r];
    end
  end

endmodule

[rtl/core/lzss_ring_decompressor_top.sv]
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_top
// LZSS decompressor with a 4096-byte history ring, byte-wide input and
// results of up to eight packed output bytes.
// ----------------------------------------------------------------------------
// After reset the block sweeps the history ring to zero, one byte per cycle,
// and holds full high throughout the sweep; output_limit may be written
// meanwhile. A parser takes one compressed byte per cycle while its command
// queue has room. The executor behind it fetches each command in an idle
// state, then writes a literal into the ring, or for each byte of a copy
// does a ring read followed by a ring write; a write waits while a finished
// result meets a full result queue. Flag bytes, the low byte of a reference
// and dropped bytes cost the executor nothing.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor_top
  import lzss_pkg::*;
#(
  parameter int BYTES_PER_RESULT = BPR_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_output_limit,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_src_byte,
  input  logic               in_block_start,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        out_bytes,
  output logic [3:0]         out_byte_count,
  output logic [RING_AW-1:0] out_ring_pos,
  output logic               out_limit_reached,
  output logic               out_last
);

  logic [CNT_W-1:0] output_limit_r;
  logic             in_accept;
  logic             cmdq_push, cmdq_full, cmdq_empty, cmdq_pop;
  cmd_t             cmdq_wdata, cmdq_rdata;
  logic             outq_push, outq_full;
  out_t             outq_wdata, outq_rdata;
  bk_status_t       bk_status;

  assign cfg_ready = 1'b1;
  assign full      = cmdq_full || bk_status.clearing;
  assign in_accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      output_limit_r <= cfg_output_limit;
    end
  end

  lzss_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .src_byte     (in_src_byte),
    .block_start  (in_block_start),
    .output_limit (output_limit_r),
    .cmd_push     (cmdq_push),
    .cmd          (cmdq_wdata)
  );

  lzss_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmdq_push),
    .wdata (cmdq_wdata),
    .full  (cmdq_full),
    .pop   (cmdq_pop),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty)
  );

  lzss_back #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .output_limit (output_limit_r),
    .cmd_empty    (cmdq_empty),
    .cmd          (cmdq_rdata),
    .cmd_pop      (cmdq_pop),
    .out_full     (outq_full),
    .out_push     (outq_push),
    .out_item     (outq_wdata),
    .status       (bk_status)
  );

  lzss_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (outq_push),
    .wdata (outq_wdata),
    .full  (outq_full),
    .pop   (pop),
    .rdata (outq_rdata),
    .empty (empty)
  );

  assign out_bytes         = outq_rdata.bytes;
  assign out_byte_count    = outq_rdata.byte_count;
  assign out_ring_pos      = outq_rdata.ring_pos;
  assign out_limit_reached = outq_rdata.limit_reached;
  assign out_last          = outq_rdata.last;

  // the parser never pushes into a full command queue
  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_push |-> !cmdq_full)
    else $error("command queue overflow");

  // no results while the ring is being cleared
  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.clearing |-> !outq_push)
    else $error("result produced during ring clear");

  // no command leaves the queue while the ring is being cleared
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.clearing |-> !cmdq_pop)
    else $error("command taken during ring clear");

  // every result carries between one and a full word of bytes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    outq_push |-> (outq_wdata.byte_count != 4'd0) &&
                  (outq_wdata.byte_count <= 4'(BYTES_PER_RESULT)))
    else $error("result byte count out of range");

endmodule
